FILE: sv/owsm_pkg.sv
// ----------------------------------------------------------------------------
// Omni wheel speed mixer package
// Shared constants and the CORDIC arctangent table for the speed mixer.
// ----------------------------------------------------------------------------
package owsm_pkg;

  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_DATA_WIDTH    = 16;

  // The table holds this many rotation steps.
  localparam int ATAN_ENTRIES = 24;

  // Fraction bits carried through the rotation.
  localparam int FRAC_BITS = 16;

  localparam int HEAD_W = 16;

  // Inverse CORDIC gain in Q30.
  localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

  // Product of a velocity with the gain is 2^30 scaled; this shift brings it
  // down to FRAC_BITS fraction bits.
  localparam int GAIN_SHIFT = 30 - FRAC_BITS;

  // pi/2 in binary angle units: the wheel frame offset pi/4 plus the eighth
  // turn that centers the residual angle.
  localparam logic [HEAD_W-1:0] QUARTER_TURN = 16'd16384;

  typedef logic signed [31:0] angle_t;

  // atan(2^-i) in units of 2^-32 turn, rounded.
  function automatic angle_t atan_turn(input logic [4:0] idx);
    angle_t val;
    unique case (idx)
      5'd0:  val = 32'sh20000000;
      5'd1:  val = 32'sh12E4051E;
      5'd2:  val = 32'sh09FB385B;
      5'd3:  val = 32'sh051111D4;
      5'd4:  val = 32'sh028B0D43;
      5'd5:  val = 32'sh0145D7E1;
      5'd6:  val = 32'sh00A2F61E;
      5'd7:  val = 32'sh00517C55;
      5'd8:  val = 32'sh0028BE53;
      5'd9:  val = 32'sh00145F2F;
      5'd10: val = 32'sh000A2F98;
      5'd11: val = 32'sh000517CC;
      5'd12: val = 32'sh00028BE6;
      5'd13: val = 32'sh000145F3;
      5'd14: val = 32'sh0000A2FA;
      5'd15: val = 32'sh0000517D;
      5'd16: val = 32'sh000028BE;
      5'd17: val = 32'sh0000145F;
      5'd18: val = 32'sh00000A30;
      5'd19: val = 32'sh00000518;
      5'd20: val = 32'sh0000028C;
      5'd21: val = 32'sh00000146;
      5'd22: val = 32'sh000000A3;
      5'd23: val = 32'sh00000051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: sv/omni_wheel_speed_mixer.sv
// ----------------------------------------------------------------------------
// Omni wheel speed mixer
// Rotates a planar velocity command into the 45-degree wheel frame of a
// four-wheel omni chassis and adds the spin term to each wheel.
// ----------------------------------------------------------------------------

// The mixer takes one command per clock cycle while in_stall_o is low and
// returns one set of four wheel speeds per command, in order. One stage
// multiplies the velocities by the inverse CORDIC gain, one applies the
// quarter-turn pre-rotation, one stage per CORDIC micro-rotation follows
// (CORDIC_STAGES of them, capped at ATAN_ENTRIES), and a last stage rounds
// and mixes in the spin. A stall on the output only holds back the input once
// every pipeline stage is occupied, so empty slots fill up while a result waits to be transferred.
module omni_wheel_speed_mixer
  import owsm_pkg::*;
#(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
  parameter int DATA_WIDTH    = DEF_DATA_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] vel_x_i,
  input  logic signed [DATA_WIDTH-1:0] vel_y_i,
  input  logic signed [DATA_WIDTH-1:0] spin_i,
  input  logic        [HEAD_W-1:0]     heading_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH+1:0] fl_speed_o,
  output logic signed [DATA_WIDTH+1:0] fr_speed_o,
  output logic signed [DATA_WIDTH+1:0] rl_speed_o,
  output logic signed [DATA_WIDTH+1:0] rr_speed_o
);

  localparam int NS  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int NST = NS + 3;                       // pipeline stages
  localparam int PW  = DATA_WIDTH + 31;              // gain product
  localparam int SW  = PW - GAIN_SHIFT;              // scaled velocity
  localparam int XW  = DATA_WIDTH + FRAC_BITS + 3;   // rotation datapath
  localparam int RW  = XW - FRAC_BITS;               // rounded rotation
  localparam int OW  = DATA_WIDTH + 2;               // wheel speed

  // Stage map: 0 multiply, 1 pre-rotation, 2..NS+1 micro-rotations, NS+2 mix.
  logic [NST-1:0] valid_q;
  logic [NST-1:0] ready;

  logic signed [PW-1:0]         prod_x_q, prod_y_q;
  logic        [HEAD_W-1:0]     turn_q;
  logic signed [DATA_WIDTH-1:0] spin_q [NS+2];
  logic signed [XW-1:0]         x_q [NS+1];
  logic signed [XW-1:0]         y_q [NS+1];
  angle_t                       z_q [NS+1];

  logic signed [OW-1:0] fl_q, fr_q, rl_q, rr_q;

  // A stage may load when some stage at or after it is empty, or when the
  // output is not stalled.
  for (genvar k = 0; k < NST; k++) begin : g_ready
    assign ready[k] = !out_stall_i || !(&valid_q[NST-1:k]);
  end

  assign in_stall_o = !ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 0: scale by the inverse gain and form the turn from the heading.
  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      prod_x_q  <= PW'(vel_x_i) * PW'(GAIN_Q30);
      prod_y_q  <= PW'(vel_y_i) * PW'(GAIN_Q30);
      turn_q    <= QUARTER_TURN - heading_i;
      spin_q[0] <= spin_i;
    end
  end

  // Stage 1: round to FRAC_BITS, turn by whole quadrants, load the residual.
  logic signed [PW-1:0] prod_x_rnd, prod_y_rnd;
  logic signed [SW-1:0] sx, sy;
  logic signed [XW-1:0] ex, ey;
  logic signed [13:0]   resid;

  always_comb begin
    prod_x_rnd = prod_x_q + PW'(1 << (GAIN_SHIFT - 1));
    prod_y_rnd = prod_y_q + PW'(1 << (GAIN_SHIFT - 1));
    sx         = prod_x_rnd[PW-1:GAIN_SHIFT];
    sy         = prod_y_rnd[PW-1:GAIN_SHIFT];
    ex         = XW'(sx);
    ey         = XW'(sy);
    // Low bits of the turn, recentered to [-8192, 8191].
    resid      = {~turn_q[13], turn_q[12:0]};
  end

  always_ff @(posedge clk_i) begin
    if (ready[1]) begin
      unique case (turn_q[15:14])
        2'd0: begin x_q[0] <= ex;  y_q[0] <= ey;  end
        2'd1: begin x_q[0] <= -ey; y_q[0] <= ex;  end
        2'd2: begin x_q[0] <= -ex; y_q[0] <= -ey; end
        2'd3: begin x_q[0] <= ey;  y_q[0] <= -ex; end
        default: begin x_q[0] <= ex; y_q[0] <= ey; end
      endcase
      z_q[0]    <= {{2{resid[13]}}, resid, 16'h0000};
      spin_q[1] <= spin_q[0];
    end
  end

  // Micro-rotations, one per stage.
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [XW-1:0] dx, dy;
    angle_t               step;

    assign dx   = y_q[i] >>> i;
    assign dy   = x_q[i] >>> i;
    assign step = atan_turn(5'(i));

    always_ff @(posedge clk_i) begin
      if (ready[i+2]) begin
        if (!z_q[i][31]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - step;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + step;
        end
        spin_q[i+2] <= spin_q[i+1];
      end
    end
  end

  // Last stage: round to whole units and mix in the spin.
  logic signed [XW-1:0] x_rnd, y_rnd;
  logic signed [RW-1:0] rx, ry, w;
  logic signed [RW-1:0] fl_d, fr_d, rl_d, rr_d;

  always_comb begin
    x_rnd = x_q[NS] + XW'(1 << (FRAC_BITS - 1));
    y_rnd = y_q[NS] + XW'(1 << (FRAC_BITS - 1));
    rx    = x_rnd[XW-1:FRAC_BITS];
    ry    = y_rnd[XW-1:FRAC_BITS];
    w     = RW'(spin_q[NS+1]);
    fl_d  = w + rx;
    fr_d  = w - ry;
    rl_d  = w + ry;
    rr_d  = w - rx;
  end

  always_ff @(posedge clk_i) begin
    if (ready[NST-1]) begin
      fl_q <= fl_d[OW-1:0];
      fr_q <= fr_d[OW-1:0];
      rl_q <= rl_d[OW-1:0];
      rr_q <= rr_d[OW-1:0];
    end
  end

  assign out_valid_o = valid_q[NST-1];
  assign fl_speed_o  = fl_q;
  assign fr_speed_o  = fr_q;
  assign rl_speed_o  = rl_q;
  assign rr_speed_o  = rr_q;

endmodule
